/* rtl/ellsmv_pkg.sv */
// ----------------------------------------------------------------------------
// ellsmv_pkg
// Shared constants, codes and types of the ELLPACK sparse matrix-vector block.
// ----------------------------------------------------------------------------
package ellsmv_pkg;

  localparam int unsigned DEF_VECTOR_DEPTH = 4096;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned EPR_W      = 8;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // mode, index, value, prior_y packed from bit 0, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 80;
  // y_value, row_index
  localparam int unsigned OUT_TDATA_W = 48;

  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ENTRY = 2'd1,
    MODE_START = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRIES = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_BETA    = 2'd2
  } cfg_e;

  typedef struct packed {
    logic             first;
    logic             row_end;
    logic [ROW_W-1:0] row;
    logic             last_row;
  } ent_ctl_t;

  typedef struct packed {
    logic [VAL_W-1:0] y;
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic             sat;
  } res_t;

endpackage

/* rtl/ell_sparse_matvec.sv */
// ----------------------------------------------------------------------------
// ell_sparse_matvec
// ELLPACK sparse matrix-vector product y = A*x + beta*y in Q16.16.
// ----------------------------------------------------------------------------
// The block takes one request per clock while s_axis_tready is high: a
// vector load, a matrix entry or a product start. Loads write the vector
// store (one RAM with a registered read port); entries read it, pass through
// a two-multiplier stage and a saturating 64-bit accumulate loop, which sets
// the rate of one entry per cycle. A row result enters an eight-deep result
// queue once it has passed the stage 1, product and row-sum registers;
// s_axis_tready drops while eight results are owed to the output side.
// There is no clearing pass after reset; a vector element must be loaded
// before an entry reads it.
// ----------------------------------------------------------------------------
module ell_sparse_matvec #(
  parameter int unsigned VECTOR_DEPTH = ellsmv_pkg::DEF_VECTOR_DEPTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // mode[1:0], index[13:2], value[45:14], prior_y[77:46], zero pad
  input  logic [ellsmv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // y_value[31:0], row_index[47:32]
  output logic [ellsmv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // saturated
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we_i,
  input  logic [ellsmv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ellsmv_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ellsmv_pkg::*;

  localparam int unsigned AddrW = $clog2(VECTOR_DEPTH);

  logic [EPR_W-1:0]     epr_q;
  logic [ROW_W-1:0]     rows_q;
  logic [VAL_W-1:0]     beta_q;

  logic [EPR_W-1:0]     entry_cnt_q, entry_cnt_d;
  logic [ROW_W-1:0]     row_cnt_q, row_cnt_d;
  logic [OUT_CNT_W-1:0] pending_q, pending_d;

  logic [MODE_W-1:0]    in_mode;
  logic [IDX_W-1:0]     in_index;
  logic [VAL_W-1:0]     in_value;
  logic [VAL_W-1:0]     in_prior;
  logic                 accept;
  logic                 in_range;
  logic [AddrW-1:0]     addr;

  logic                 load_go;
  logic                 entry_go;
  logic                 start_go;

  logic [EPR_W-1:0]     cnt_inc;
  logic [EPR_W-1:0]     limit;
  logic                 row_end;
  logic [ROW_W:0]       row_inc;
  logic                 is_last;
  ent_ctl_t             ent_ctl;

  logic [VAL_W-1:0]     rdata;
  logic                 res_valid;
  res_t                 res;
  res_t                 out_res;
  logic                 out_pop;

  assign in_mode  = s_axis_tdata[MODE_W-1:0];
  assign in_index = s_axis_tdata[MODE_W +: IDX_W];
  assign in_value = s_axis_tdata[MODE_W+IDX_W +: VAL_W];
  assign in_prior = s_axis_tdata[MODE_W+IDX_W+VAL_W +: VAL_W];

  assign s_axis_tready = (pending_q < OUT_CNT_W'(OUT_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(in_index) < VECTOR_DEPTH);
  assign addr          = AddrW'(in_index);

  always_comb begin
    load_go  = 1'b0;
    entry_go = 1'b0;
    start_go = 1'b0;
    case (in_mode)
      MODE_LOAD:  load_go  = accept;
      MODE_ENTRY: entry_go = accept;
      MODE_START: start_go = accept;
      default: ;
    endcase
  end

  assign cnt_inc = entry_cnt_q + EPR_W'(1);
  assign limit   = (epr_q == '0) ? EPR_W'(1) : epr_q;
  assign row_end = (cnt_inc == '0) || (cnt_inc >= limit);
  assign row_inc = {1'b0, row_cnt_q} + (ROW_W+1)'(1);
  assign is_last = (row_inc >= {1'b0, rows_q});

  always_comb begin
    ent_ctl.first    = (entry_cnt_q == '0);
    ent_ctl.row_end  = row_end;
    ent_ctl.row      = row_cnt_q;
    ent_ctl.last_row = is_last;
  end

  always_comb begin
    entry_cnt_d = entry_cnt_q;
    row_cnt_d   = row_cnt_q;
    if (start_go) begin
      entry_cnt_d = '0;
      row_cnt_d   = '0;
    end else if (entry_go) begin
      entry_cnt_d = row_end ? '0 : cnt_inc;
      if (row_end) begin
        row_cnt_d = is_last ? '0 : row_inc[ROW_W-1:0];
      end
    end
  end

  assign out_pop   = m_axis_tvalid && m_axis_tready;
  assign pending_d = pending_q + OUT_CNT_W'(entry_go && row_end) - OUT_CNT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epr_q       <= EPR_W'(1);
      rows_q      <= ROW_W'(1);
      beta_q      <= '0;
      entry_cnt_q <= '0;
      row_cnt_q   <= '0;
      pending_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENTRIES: epr_q  <= cfg_data_i[EPR_W-1:0];
          CFG_ROWS:    rows_q <= cfg_data_i[ROW_W-1:0];
          CFG_BETA:    beta_q <= cfg_data_i[VAL_W-1:0];
          default: ;
        endcase
      end
      entry_cnt_q <= entry_cnt_d;
      row_cnt_q   <= row_cnt_d;
      pending_q   <= pending_d;
    end
  end

  ellsmv_ram #(
    .Width (VAL_W),
    .Depth (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (load_go && in_range),
    .waddr_i (addr),
    .wdata_i (in_value),
    .re_i    (entry_go && in_range),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  ellsmv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (entry_go),
    .ent_ctl_i   (ent_ctl),
    .value_i     (in_value),
    .prior_i     (in_prior),
    .in_range_i  (in_range),
    .beta_i      (beta_q),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ellsmv_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {out_res.row, out_res.y};
  assign m_axis_tlast = out_res.last_row;
  assign m_axis_tuser = out_res.sat;

  a_pending_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credit count exceeds queue depth");

  a_out_owed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pending_q != '0))
    else $error("output valid with no result owed");

  a_row_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_go && row_end) |=> (entry_cnt_q == '0))
    else $error("entry counter not cleared at row end");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_go |=> (entry_cnt_q == '0) && (row_cnt_q == '0))
    else $error("start request did not clear counters");

endmodule

/* rtl/ellsmv_ram.sv */
// ----------------------------------------------------------------------------
// ellsmv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ellsmv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ellsmv_mac.sv */
// ----------------------------------------------------------------------------
// ellsmv_mac
// Multiply, accumulate and round pipeline: products, saturating Q32.32 row
// sum, rounding and clipping of the finished row to Q16.16.
// ----------------------------------------------------------------------------
module ellsmv_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  ent_valid_i,
  input  ellsmv_pkg::ent_ctl_t                  ent_ctl_i,
  input  logic signed [ellsmv_pkg::VAL_W-1:0]   value_i,
  input  logic signed [ellsmv_pkg::VAL_W-1:0]   prior_i,
  input  logic                                  in_range_i,
  input  logic signed [ellsmv_pkg::VAL_W-1:0]   beta_i,
  input  logic        [ellsmv_pkg::VAL_W-1:0]   rdata_i,
  output logic                                  res_valid_o,
  output ellsmv_pkg::res_t                      res_o
);
  import ellsmv_pkg::*;

  localparam int unsigned QW = ACC_W - 16 + 1;

  logic                    s1_valid_q;
  ent_ctl_t                s1_ctl_q;
  logic signed [VAL_W-1:0] s1_val_q;
  logic signed [VAL_W-1:0] s1_prior_q;
  logic                    s1_in_range_q;

  logic signed [VAL_W-1:0] xv;
  logic signed [ACC_W-1:0] prod_d;
  logic signed [ACC_W-1:0] seed_d;

  logic                    s2_valid_q;
  ent_ctl_t                s2_ctl_q;
  logic signed [ACC_W-1:0] s2_prod_q;
  logic signed [ACC_W-1:0] s2_seed_q;

  logic [ACC_W-1:0]        acc_q;
  logic [ACC_W-1:0]        base;
  logic [ACC_W-1:0]        sum_raw;
  logic                    ovf;
  logic [ACC_W-1:0]        acc_d;

  logic                    s3_valid_q;
  logic [ACC_W-1:0]        s3_sum_q;
  logic [ROW_W-1:0]        s3_row_q;
  logic                    s3_last_q;

  logic [QW-1:0]           q;
  logic                    clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ent_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && s2_ctl_q.row_end;
    end
  end

  // stage 1: vector element arrives from the store
  always_ff @(posedge clk_i) begin
    s1_ctl_q      <= ent_ctl_i;
    s1_val_q      <= value_i;
    s1_prior_q    <= prior_i;
    s1_in_range_q <= in_range_i;
  end

  assign xv     = s1_in_range_q ? $signed(rdata_i) : '0;
  assign prod_d = s1_val_q * xv;
  assign seed_d = s1_prior_q * beta_i;

  // stage 2: products
  always_ff @(posedge clk_i) begin
    s2_ctl_q  <= s1_ctl_q;
    s2_prod_q <= prod_d;
    s2_seed_q <= seed_d;
  end

  assign base    = s2_ctl_q.first ? s2_seed_q : acc_q;
  assign sum_raw = base + s2_prod_q;
  assign ovf     = (base[ACC_W-1] == s2_prod_q[ACC_W-1]) &&
                   (sum_raw[ACC_W-1] != base[ACC_W-1]);

  always_comb begin
    acc_d = sum_raw;
    if (ovf) begin
      acc_d = base[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // stage 3: row sum
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    s3_sum_q  <= acc_d;
    s3_row_q  <= s2_ctl_q.row;
    s3_last_q <= s2_ctl_q.last_row;
  end

  assign q    = {s3_sum_q[ACC_W-1], s3_sum_q[ACC_W-1:16]} + QW'(s3_sum_q[15]);
  assign clip = !((&q[QW-1:VAL_W-1]) || (~|q[QW-1:VAL_W-1]));

  always_comb begin
    res_o.y        = q[VAL_W-1:0];
    if (clip) begin
      res_o.y = q[QW-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    res_o.row      = s3_row_q;
    res_o.last_row = s3_last_q;
    res_o.sat      = clip;
  end

  assign res_valid_o = s3_valid_q;

endmodule

/* rtl/ellsmv_fifo.sv */
// ----------------------------------------------------------------------------
// ellsmv_fifo
// Result queue between the arithmetic pipeline and the output stream.
// ----------------------------------------------------------------------------
module ellsmv_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ellsmv_pkg::res_t push_data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ellsmv_pkg::res_t data_o
);
  import ellsmv_pkg::*;

  res_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + OUT_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
